// ===== sv/move_time_accel_solver_top_defines.svh =====
`ifndef MOVE_TIME_ACCEL_SOLVER_TOP_DEFINES_SVH
`define MOVE_TIME_ACCEL_SOLVER_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define MTAS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MTAS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mtas_pkg.sv =====
package mtas_pkg;

  localparam int STEP_W = 24;
  localparam int SPD_W  = 16;
  localparam int ACC_W  = 20;
  localparam int TIME_W = 32;

  localparam logic [ACC_W-1:0] ACC_FLOOR = ACC_W'(10);

  typedef logic [STEP_W-1:0] steps_t;
  typedef logic [SPD_W-1:0]  speed_t;
  typedef logic [ACC_W-1:0]  accel_t;
  typedef logic [TIME_W-1:0] mtime_t;

endpackage

// ===== sv/mtas_req_if.sv =====
interface mtas_req_if import mtas_pkg::*; ();
  logic   valid;
  logic   ready;
  steps_t move_steps;
  speed_t start_speed;
  speed_t top_speed;
  accel_t accel_limit;
  mtime_t move_time;

  modport source (output valid, output move_steps, output start_speed, output top_speed,
                  output accel_limit, output move_time, input ready);
  modport sink   (input valid, input move_steps, input start_speed, input top_speed,
                  input accel_limit, input move_time, output ready);
endinterface

// ===== sv/mtas_rsp_if.sv =====
interface mtas_rsp_if import mtas_pkg::*; ();
  logic   valid;
  logic   ready;
  accel_t accel;
  logic   bad_speeds;

  modport source (output valid, output accel, output bad_speeds, input ready);
  modport sink   (input valid, input accel, input bad_speeds, output ready);
endinterface

// ===== sv/move_time_accel_solver_top.sv =====
// channel | dir | word contents
// req     | in  | move_steps, start_speed, top_speed, accel_limit, move_time
// rsp     | out | accel, bad_speeds
//
// one word accepted per cycle while the output is not stalled, one result per word, in order
// the pipeline has four setup stages, a one-bit-per-stage divider of
// 21 stages (range check plus 20 quotient bits), and the output register
// the divider depth follows from the 20-bit acceleration width
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
// reset clears the valid bits only
`include "move_time_accel_solver_top_defines.svh"

module move_time_accel_solver_top import mtas_pkg::*; #(
  parameter int TIME_FRAC_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  mtas_req_if.sink    req,
  mtas_rsp_if.source  rsp
);

  localparam int F    = TIME_FRAC_BITS;
  localparam int KW   = TIME_W + 1 - F;
  localparam int KLW  = KW + ACC_W;
  localparam int MW   = KLW + 1;
  localparam int SLW  = STEP_W + ACC_W;
  localparam int SQW  = 2 * SPD_W;
  localparam int XW   = SLW + 1;
  localparam int MRT  = (XW + 1) / 2;
  localparam int MSW  = 2 * MRT;
  localparam int LVW  = ACC_W + SPD_W;
  localparam int LKW  = LVW + KW;
  localparam int TW   = (LKW > XW) ? LKW : XW;
  localparam int PW   = SPD_W + TIME_W;
  localparam int SMW  = PW + 1;
  localparam int DW   = 2 * TIME_W;
  localparam int SFW  = STEP_W + F;
  localparam int VW   = (SFW > PW) ? SFW : PW;
  localparam int CW   = (SFW + 1 > SMW) ? SFW + 1 : SMW;
  localparam int NW   = VW + F + 2;
  localparam int OW   = (NW > DW + ACC_W) ? NW : DW + ACC_W;
  localparam int QW   = ACC_W + 1;
  localparam int LAST = ACC_W + 1;

  typedef struct packed {
    logic            go;
    logic            bad;
    accel_t          lim;
    logic            use_div;
    logic [QW-1:0]   qdir;
    logic            ovf;
    logic [NW-1:0]   rem;
    logic [DW-1:0]   den;
    logic [ACC_W-1:0] q;
  } dstage_t;

  logic en;
  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // stage 1: products straight from the input word
  logic              pv1;
  logic [SLW-1:0]    p1_sl;
  logic [SQW-1:0]    p1_v0sq, p1_vmsq;
  speed_t            p1_dv, p1_v0;
  logic              p1_bad, p1_go, p1_vmz, p1_tpos;
  logic [KW-1:0]     p1_k1;
  logic [KLW-1:0]    p1_kl;
  logic [LVW-1:0]    p1_lv;
  logic [PW-1:0]     p1_vt, p1_pos;
  logic [SMW-1:0]    p1_sumt;
  logic [DW-1:0]     p1_tt;
  logic [SFW-1:0]    p1_sf;
  accel_t            p1_lim;

  mtime_t            tm1;
  logic [KW-1:0]     k1;

  always_comb begin
    tm1 = req.move_time - TIME_W'(1);
    k1  = KW'({1'b0, tm1[TIME_W-1:F]}) + KW'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_sl   <= SLW'(req.move_steps) * SLW'(req.accel_limit);
      p1_v0sq <= SQW'(req.start_speed) * SQW'(req.start_speed);
      p1_vmsq <= SQW'(req.top_speed) * SQW'(req.top_speed);
      p1_dv   <= req.top_speed - req.start_speed;
      p1_v0   <= req.start_speed;
      p1_bad  <= req.top_speed < req.start_speed;
      p1_go   <= !(req.top_speed < req.start_speed) && (req.move_steps != '0)
                 && (req.accel_limit != '0);
      p1_vmz  <= req.top_speed == '0;
      p1_tpos <= req.move_time != '0;
      p1_k1   <= k1;
      p1_kl   <= KLW'(k1) * KLW'(req.accel_limit);
      p1_lv   <= LVW'(req.accel_limit) * LVW'(req.top_speed);
      p1_vt   <= PW'(req.start_speed) * PW'(req.move_time);
      p1_pos  <= PW'(req.top_speed) * PW'(req.move_time);
      p1_sumt <= SMW'({1'b0, req.top_speed} + {1'b0, req.start_speed})
                 * SMW'(req.move_time);
      p1_tt   <= DW'(req.move_time) * DW'(req.move_time);
      p1_sf   <= {req.move_steps, {F{1'b0}}};
      p1_lim  <= req.accel_limit;
    end
  end

  // stage 2: squares, sums and the time compares
  logic              pv2;
  logic [SQW-1:0]    p2_dv2;
  logic [XW-1:0]     p2_x;
  logic [KLW-1:0]    p2_m;
  logic              p2_tri, p2_fitc, p2_fitneg, p2_peq, p2_plt;
  logic [LKW-1:0]    p2_lvk;
  logic [VW-1:0]     p2_fitnum, p2_d2;
  logic [DW-1:0]     p2_tt;
  logic [SLW-1:0]    p2_sl;
  accel_t            p2_lim;
  logic              p2_go, p2_bad, p2_vmz, p2_tpos;
  logic [MW-1:0]     msum;

  assign msum = MW'(p1_kl) + MW'({p1_v0, 1'b0}) + MW'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      p2_dv2    <= SQW'(p1_dv) * SQW'(p1_dv);
      p2_x      <= XW'(p1_v0sq) + XW'(p1_sl);
      // triangle run fits when isqrt(x) < m
      p2_m      <= msum[MW-1:1];
      p2_tri    <= p1_sl <= SLW'(p1_vmsq - p1_v0sq);
      p2_lvk    <= LKW'(p1_lv) * LKW'(p1_k1);
      p2_fitc   <= CW'({p1_sf, 1'b0}) <= CW'(p1_sumt);
      p2_fitneg <= VW'(p1_sf) < VW'(p1_vt);
      p2_fitnum <= VW'(p1_sf) - VW'(p1_vt);
      p2_peq    <= VW'(p1_pos) == VW'(p1_sf);
      p2_plt    <= VW'(p1_pos) < VW'(p1_sf);
      p2_d2     <= VW'(p1_pos) - VW'(p1_sf);
      p2_tt     <= p1_tt;
      p2_sl     <= p1_sl;
      p2_lim    <= p1_lim;
      p2_go     <= p1_go;
      p2_bad    <= p1_bad;
      p2_vmz    <= p1_vmz;
      p2_tpos   <= p1_tpos;
    end
  end

  // stage 3: square of the triangle bound, trapezoid run check
  logic              pv3;
  logic              p3_mbig, p3_trapok, p3_dv2z;
  logic [MSW-1:0]    p3_msq;
  logic [XW-1:0]     p3_x;
  logic [SQW-1:0]    p3_dv2;
  logic              p3_tri, p3_fitc, p3_fitneg, p3_peq, p3_plt;
  logic [VW-1:0]     p3_fitnum, p3_d2;
  logic [DW-1:0]     p3_tt;
  accel_t            p3_lim;
  logic              p3_go, p3_bad, p3_vmz, p3_tpos;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_mbig   <= |p2_m[KLW-1:MRT];
      p3_msq    <= MSW'(p2_m[MRT-1:0]) * MSW'(p2_m[MRT-1:0]);
      p3_trapok <= p2_tpos && (TW'(XW'(p2_dv2) + XW'(p2_sl)) < TW'(p2_lvk));
      p3_dv2z   <= p2_dv2 == '0;
      p3_x      <= p2_x;
      p3_dv2    <= p2_dv2;
      p3_tri    <= p2_tri;
      p3_fitc   <= p2_fitc;
      p3_fitneg <= p2_fitneg;
      p3_peq    <= p2_peq;
      p3_plt    <= p2_plt;
      p3_fitnum <= p2_fitnum;
      p3_d2     <= p2_d2;
      p3_tt     <= p2_tt;
      p3_lim    <= p2_lim;
      p3_go     <= p2_go;
      p3_bad    <= p2_bad;
      p3_vmz    <= p2_vmz;
      p3_tpos   <= p2_tpos;
    end
  end

  // stage 4: pick the profile branch and the division to run
  dstage_t        dd [0:LAST];
  logic [LAST:0]  ddv;
  dstage_t        dec;
  logic           tri_ok, fit_go;

  always_comb begin
    tri_ok      = p3_tpos && (p3_mbig || (MSW'(p3_x) < p3_msq));
    fit_go      = 1'b0;
    dec         = '0;
    dec.go      = p3_go;
    dec.bad     = p3_bad;
    dec.lim     = p3_lim;
    dec.qdir    = QW'(p3_lim);
    if (p3_tri) begin
      fit_go = tri_ok;
    end else if (p3_vmz || !p3_trapok) begin
      fit_go = 1'b0;
    end else if (p3_fitc) begin
      fit_go = 1'b1;
    end else if (p3_peq) begin
      fit_go = 1'b0;
    end else if (p3_plt) begin
      if (p3_dv2z) begin
        dec.qdir = '0;
      end
    end else begin
      dec.use_div = 1'b1;
      dec.rem     = NW'({p3_dv2, {F{1'b0}}});
      dec.den     = DW'(p3_d2);
    end
    if (fit_go && !p3_fitneg) begin
      dec.use_div = 1'b1;
      dec.rem     = {p3_fitnum, {(F + 2){1'b0}}};
      dec.den     = p3_tt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv1 <= 1'b0;
      pv2 <= 1'b0;
      pv3 <= 1'b0;
      ddv <= '0;
    end else if (en) begin
      pv1 <= req.valid;
      pv2 <= pv1;
      pv3 <= pv2;
      ddv <= {ddv[LAST-1:0], pv3};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= dec;
    end
  end

  // quotient of 2^20 or more always exceeds the limit
  dstage_t dd1_next;

  always_comb begin
    dd1_next     = dd[0];
    dd1_next.ovf = OW'(dd[0].rem) >= (OW'(dd[0].den) << ACC_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[1] <= dd1_next;
    end
  end

  for (genvar j = 2; j <= LAST; j++) begin : g_bit
    localparam int B = LAST - j;
    logic [OW-1:0] trial, remx;
    logic          take;
    dstage_t       dd_next;

    always_comb begin
      trial   = OW'(dd[j-1].den) << B;
      remx    = OW'(dd[j-1].rem);
      take    = remx >= trial;
      dd_next = dd[j-1];
      if (take) begin
        dd_next.rem  = NW'(remx - trial);
        dd_next.q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dd[j] <= dd_next;
      end
    end
  end

  // clamp to [floor, limit]; a word with go clear gets the limit
  logic [QW-1:0] qsel;
  accel_t        res_acc;

  always_comb begin
    if (!dd[LAST].use_div) begin
      qsel = dd[LAST].qdir;
    end else if (dd[LAST].ovf) begin
      qsel = QW'(1) << ACC_W;
    end else begin
      qsel = {1'b0, dd[LAST].q};
    end
    if (!dd[LAST].go || qsel >= QW'(dd[LAST].lim)) begin
      res_acc = dd[LAST].lim;
    end else if (qsel < QW'(ACC_FLOOR)) begin
      res_acc = ACC_FLOOR;
    end else begin
      res_acc = qsel[ACC_W-1:0];
    end
  end

  logic   outv;
  accel_t out_acc;
  logic   out_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      outv <= 1'b0;
    end else if (en) begin
      outv <= ddv[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_acc <= res_acc;
      out_bad <= dd[LAST].bad;
    end
  end

  assign rsp.valid      = outv;
  assign rsp.accel      = out_acc;
  assign rsp.bad_speeds = out_bad;

  `MTAS_ASSERT_IMP(a_den_nonzero, clk, rst, ddv[1] && dd[1].use_div, dd[1].den != '0, "divider fed a zero divisor")
  `MTAS_ASSERT_NXT(a_word_enters, clk, rst, req.valid && req.ready, pv1, "accepted word lost at entry")
  `MTAS_ASSERT_NXT(a_stall_freezes, clk, rst, !en, $stable(ddv) && $stable(pv3), "pipeline moved while stalled")
  `MTAS_ASSERT_IMP(a_bad_gives_lim, clk, rst, ddv[LAST] && dd[LAST].bad, res_acc == dd[LAST].lim, "bad speeds did not give the limit")

endmodule
